[src/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Action codes, register indexes, the sequencer state type, the per-term tag
// that travels down the multiply-accumulate pipeline, and dimension clamping.
// ----------------------------------------------------------------------------
package mme_pkg;

	// default maximum matrix dimension (store is MAX_DIM x MAX_DIM)
	localparam int MAX_DIM_DEF = 8;

	// hard cap on the usable dimension, set by the 3-bit index fields
	localparam int DIM_LIMIT = 8;

	// width of a dimension register
	localparam int DIM_W = 4;

	// action codes of an input word
	localparam logic [1:0] ACT_LOAD_A  = 2'd0;
	localparam logic [1:0] ACT_LOAD_B  = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	// sequencer states
	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// tag of one multiply-accumulate term
	typedef struct packed {
		logic       valid;  // term is live
		logic       first;  // first term of a result element
		logic       fin;    // final term of a result element
		logic       last;   // belongs to the final element of the matrix
		logic [2:0] row;
		logic [2:0] col;
	} mac_tag_t;

	// clamp a dimension register: zero acts as one, large values as the cap
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] cap);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > cap) begin
			r = cap;
		end
		return r;
	endfunction

endpackage

[src/matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine: general matrix multiply on signed Q16.16
// Loads A and B one element per word into two element stores, and on a
// compute word emits C = A x B in row-major order, one element per word.
//
//   channel   handshake                  payload
//   in        in_valid / in_stall        action, row_index, col_index, element
//   out       out_valid / out_stall      out_row, out_col, product, last
//   cfg       APB psel/penable/pready    paddr, pwdata, prdata
//
// The stores give one read pair per cycle, while no result is stalled, to
// one multiply-accumulate unit.
// Reset clears control, sets configuration to one; store contents undefined.
// in_stall is high while a compute is in flight; a stalled result freezes
// the whole multiply-accumulate pipeline until it is taken.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [2:0]  row_index,
	input  logic [2:0]  col_index,
	input  logic [31:0] element,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_row,
	output logic [2:0]  out_col,
	output logic [31:0] product,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import mme_pkg::*;

	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int AW      = $clog2(DEPTH);
	localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [DIM_W-1:0] dim_m, dim_n, dim_p;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	logic             in_acc, start, in_range, we_a, we_b;
	logic [AW-1:0]    waddr;
	logic             hold, seq_busy, mac_busy, rd_en;
	logic [AW-1:0]    addr_a, addr_b;
	logic [31:0]      a_data, b_data;
	mac_tag_t         tag;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(1);
			inner_dim_q <= DIM_W'(1);
			cols_b_q    <= DIM_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ROWS_A:    rows_a_q    <= pwdata[DIM_W-1:0];
				REG_INNER_DIM: inner_dim_q <= pwdata[DIM_W-1:0];
				REG_COLS_B:    cols_b_q    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_ROWS_A:    prdata = 32'(rows_a_q);
			REG_INNER_DIM: prdata = 32'(inner_dim_q);
			REG_COLS_B:    prdata = 32'(cols_b_q);
			default:       prdata = '0;
		endcase
	end

	assign dim_m = eff_dim(rows_a_q, DIM_W'(DIM_CAP));
	assign dim_n = eff_dim(inner_dim_q, DIM_W'(DIM_CAP));
	assign dim_p = eff_dim(cols_b_q, DIM_W'(DIM_CAP));

	// input word decode
	assign in_stall = seq_busy || mac_busy;
	assign in_acc   = in_valid && !in_stall;
	assign start    = in_acc && (action == ACT_COMPUTE);
	assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
	assign we_a     = in_acc && (action == ACT_LOAD_A) && in_range;
	assign we_b     = in_acc && (action == ACT_LOAD_B) && in_range;
	assign waddr    = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);

	// pipeline freezes while a result waits at the output
	assign hold = out_valid && out_stall;

	mme_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (element),
		.re    (rd_en),
		.raddr (addr_a),
		.rdata (a_data)
	);

	mme_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (element),
		.re    (rd_en),
		.raddr (addr_b),
		.rdata (b_data)
	);

	mme_seq #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (hold),
		.dim_m  (dim_m),
		.dim_n  (dim_n),
		.dim_p  (dim_p),
		.busy   (seq_busy),
		.rd_en  (rd_en),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.tag    (tag)
	);

	mme_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (hold),
		.tag       (tag),
		.a_data    (a_data),
		.b_data    (b_data),
		.busy      (mac_busy),
		.out_valid (out_valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last)
	);

endmodule

[src/mme_store.sv]
// ----------------------------------------------------------------------------
// mme_store: element store
// Synchronous single-port-write, single-port-read memory with a registered
// read port. Read data holds while read enable is low.
// ----------------------------------------------------------------------------
module mme_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/mme_seq.sv]
// ----------------------------------------------------------------------------
// mme_seq: compute sequencer
// Walks the result in row-major order and, for each element, the inner
// dimension, issuing one pair of store reads and one term tag per cycle unless held.
// ----------------------------------------------------------------------------
module mme_seq #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
	parameter int AW      = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     hold,
	input  logic [mme_pkg::DIM_W-1:0] dim_m,
	input  logic [mme_pkg::DIM_W-1:0] dim_n,
	input  logic [mme_pkg::DIM_W-1:0] dim_p,
	output logic                     busy,
	output logic                     rd_en,
	output logic [AW-1:0]            addr_a,
	output logic [AW-1:0]            addr_b,
	output mme_pkg::mac_tag_t        tag
);

	import mme_pkg::*;

	seq_state_t state_q, state_nxt;
	logic [2:0] i_q, k_q, j_q;
	logic       j_end, k_end, i_end;

	assign j_end = ({1'b0, j_q} == dim_n - DIM_W'(1));
	assign k_end = ({1'b0, k_q} == dim_p - DIM_W'(1));
	assign i_end = ({1'b0, i_q} == dim_m - DIM_W'(1));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) state_nxt = SEQ_RUN;
			end
			SEQ_RUN: begin
				if (!hold && j_end && k_end && i_end) state_nxt = SEQ_IDLE;
			end
			default: state_nxt = SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = 1'b0;
		rd_en     = 1'b0;
		tag       = '0;
		tag.first = (j_q == 3'd0);
		tag.fin   = j_end;
		tag.last  = k_end && i_end;
		tag.row   = i_q;
		tag.col   = k_q;
		case (state_q)
			SEQ_IDLE: begin
				busy = 1'b0;
			end
			SEQ_RUN: begin
				busy      = 1'b1;
				rd_en     = !hold;
				tag.valid = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	// A[i][j] and B[j][k]
	assign addr_a = AW'(i_q) * AW'(MAX_DIM) + AW'(j_q);
	assign addr_b = AW'(j_q) * AW'(MAX_DIM) + AW'(k_q);

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == SEQ_IDLE) begin
				i_q <= '0;
				k_q <= '0;
				j_q <= '0;
			end else if (!hold) begin
				if (!j_end) begin
					j_q <= j_q + 3'd1;
				end else begin
					j_q <= '0;
					if (!k_end) begin
						k_q <= k_q + 3'd1;
					end else begin
						k_q <= '0;
						i_q <= i_q + 3'd1;
					end
				end
			end
		end
	end

endmodule

[src/mme_mac.sv]
// ----------------------------------------------------------------------------
// mme_mac: multiply-accumulate pipeline and result register
// Stage 1 aligns the term tag with the store read data, stage 2 multiplies,
// stage 3 accumulates in a wide register, and the output stage rounds to
// Q16.16 and saturates. The whole pipeline freezes while a result waits.
// ----------------------------------------------------------------------------
module mme_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hold,
	input  mme_pkg::mac_tag_t tag,
	input  logic [31:0]       a_data,
	input  logic [31:0]       b_data,
	output logic              busy,
	output logic              out_valid,
	output logic [2:0]        out_row,
	output logic [2:0]        out_col,
	output logic [31:0]       product,
	output logic              last
);

	import mme_pkg::*;

	// sum of up to eight Q32.32 products
	localparam int ACC_W = 68;
	localparam int SH_W  = ACC_W - 16;

	mac_tag_t          tag_s1, tag_s2, tag_s3;
	logic signed [63:0] prod_s2;
	logic signed [ACC_W-1:0] acc_s3;
	logic              out_valid_q;
	logic [2:0]        out_row_q, out_col_q;
	logic [31:0]       product_q;
	logic              last_q;

	logic signed [ACC_W-1:0] rnd;
	logic signed [SH_W-1:0]  sh;
	logic [31:0]             sat;

	// control: term tags down the pipe and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
			out_valid_q <= 1'b0;
		end else if (!hold) begin
			tag_s1      <= tag;
			tag_s2      <= tag_s1;
			tag_s3      <= '{valid: tag_s2.valid && tag_s2.fin, first: tag_s2.first,
				fin: tag_s2.fin, last: tag_s2.last, row: tag_s2.row, col: tag_s2.col};
			out_valid_q <= tag_s3.valid;
		end
	end

	// stage 2: multiply
	always_ff @(posedge clk) begin
		if (!hold) begin
			prod_s2 <= $signed(a_data) * $signed(b_data);
		end
	end

	// stage 3: accumulate, restarting on the first term of an element
	always_ff @(posedge clk) begin
		if (!hold) begin
			if (tag_s2.valid) begin
				if (tag_s2.first) begin
					acc_s3 <= ACC_W'(prod_s2);
				end else begin
					acc_s3 <= acc_s3 + ACC_W'(prod_s2);
				end
			end
		end
	end

	// round half up to Q16.16, then clamp to 32 bits
	always_comb begin
		rnd = acc_s3 + ACC_W'(32'h8000);
		sh  = rnd[ACC_W-1:16];
		if (sh > SH_W'(33'sh0_7FFF_FFFF)) begin
			sat = 32'h7FFF_FFFF;
		end else if (sh < -SH_W'(33'sh0_8000_0000)) begin
			sat = 32'h8000_0000;
		end else begin
			sat = sh[31:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (!hold && tag_s3.valid) begin
			out_row_q <= tag_s3.row;
			out_col_q <= tag_s3.col;
			product_q <= sat;
			last_q    <= tag_s3.last;
		end
	end

	assign busy      = tag_s1.valid || tag_s2.valid || tag_s3.valid;
	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign product   = product_q;
	assign last      = last_q;

endmodule
